FILE: hdl/pbrle_pkg.sv
// pbrle_pkg: shared constants and controller/datapath interface structs
// for the packbits run-length decoder; no dependencies
package pbrle_pkg;

	// lanes per result, kept within the four lane ports
	localparam int LANES      = 4;
	localparam int LANES_USED = (LANES < 1) ? 1 : ((LANES > 4) ? 4 : LANES);
	localparam int NUM_LANES  = 4;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 3;

	// copies still to expand and literal bytes still expected (max 129)
	localparam int LEN_W      = 8;

	// commands from controller to datapath
	typedef struct packed {
		logic ld_run_len;   // header byte starts a run
		logic ld_lit_len;   // header byte starts a literal
		logic lit_step;     // one literal byte consumed
		logic cap_run;      // capture run data byte and last flag
		logic emit_run;     // load one packed chunk of the run
		logic emit_lit;     // load one literal byte as a result
		logic emit_end;     // load the empty end-of-stream result
	} pbrle_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic hdr_is_run;   // incoming byte read as a header selects a run
		logic lit_final;    // this literal byte is the last one expected
		logic run_final;    // remaining copies fit in one result
		logic slot_free;    // output register empty or draining this cycle
	} pbrle_stat_t;

endpackage

FILE: hdl/pbrle_ctrl.sv
// pbrle_ctrl: decoder state machine, drives datapath commands and input ready
// depends on pbrle_pkg
module pbrle_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  last,
	output logic                  in_ready,
	input  pbrle_pkg::pbrle_stat_t stat,
	output pbrle_pkg::pbrle_cmd_t  cmd
);
	import pbrle_pkg::*;

	typedef enum logic [3:0] {
		S_HEAD = 4'b0001,
		S_LIT  = 4'b0010,
		S_RUNB = 4'b0100,
		S_EXP  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   take;

	// input is held off while a run expands or the output slot is busy
	assign in_ready = (state_q != S_EXP) && stat.slot_free;
	assign take     = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_HEAD: begin
				if (take) begin
					if (last) begin
						cmd.emit_end = 1'b1;
					end else if (stat.hdr_is_run) begin
						cmd.ld_run_len = 1'b1;
						state_d        = S_RUNB;
					end else begin
						cmd.ld_lit_len = 1'b1;
						state_d        = S_LIT;
					end
				end
			end
			S_LIT: begin
				if (take) begin
					cmd.lit_step = 1'b1;
					cmd.emit_lit = 1'b1;
					if (stat.lit_final || last) begin
						state_d = S_HEAD;
					end
				end
			end
			S_RUNB: begin
				if (take) begin
					cmd.cap_run = 1'b1;
					state_d     = S_EXP;
				end
			end
			S_EXP: begin
				if (stat.slot_free) begin
					cmd.emit_run = 1'b1;
					if (stat.run_final) begin
						state_d = S_HEAD;
					end
				end
			end
			default: begin
				state_d = S_HEAD;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HEAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/pbrle_dp.sv
// pbrle_dp: length counters, run byte holding and the output register
// depends on pbrle_pkg
module pbrle_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [pbrle_pkg::BYTE_W-1:0]        data_byte,
	input  logic                                last,
	input  pbrle_pkg::pbrle_cmd_t               cmd,
	output pbrle_pkg::pbrle_stat_t              stat,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [pbrle_pkg::BYTE_W-1:0]        lane0,
	output logic [pbrle_pkg::BYTE_W-1:0]        lane1,
	output logic [pbrle_pkg::BYTE_W-1:0]        lane2,
	output logic [pbrle_pkg::BYTE_W-1:0]        lane3,
	output logic [pbrle_pkg::CNT_W-1:0]         valid_count,
	output logic                                item_last,
	output logic                                stream_end
);
	import pbrle_pkg::*;

	localparam logic [LEN_W-1:0] LanesLen = LEN_W'(LANES_USED);
	localparam logic [CNT_W-1:0] LanesCnt = CNT_W'(LANES_USED);

	logic [LEN_W-1:0]  remain_q;
	logic [LEN_W-1:0]  lit_left_q;
	logic [BYTE_W-1:0] run_byte_q;
	logic              run_last_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] lane_q [NUM_LANES];
	logic [CNT_W-1:0]  cnt_q;
	logic              item_last_q;
	logic              stream_end_q;

	logic [LEN_W-1:0]  run_copies;
	logic [CNT_W-1:0]  chunk_cnt;
	logic              out_load;

	// copies of a run: 1 - h, which is (-b) + 1 over eight bits
	assign run_copies = LEN_W'(8'(8'd0 - data_byte)) + LEN_W'(1);

	assign stat.hdr_is_run = (data_byte == '0) || data_byte[BYTE_W-1];
	assign stat.lit_final  = (lit_left_q == LEN_W'(1));
	assign stat.run_final  = (remain_q <= LanesLen);
	assign stat.slot_free  = !out_valid_q || out_ready;

	assign chunk_cnt = stat.run_final ? remain_q[CNT_W-1:0] : LanesCnt;
	assign out_load  = cmd.emit_run || cmd.emit_lit || cmd.emit_end;

	// run and literal counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q   <= '0;
			lit_left_q <= '0;
		end else begin
			if (cmd.ld_run_len) begin
				remain_q <= run_copies;
			end else if (cmd.emit_run) begin
				remain_q <= remain_q - LEN_W'(chunk_cnt);
			end
			if (cmd.ld_lit_len) begin
				lit_left_q <= data_byte + LEN_W'(1);
			end else if (cmd.lit_step) begin
				lit_left_q <= lit_left_q - LEN_W'(1);
			end
		end
	end

	// run data byte and its last flag
	always_ff @(posedge clk) begin
		if (cmd.cap_run) begin
			run_byte_q <= data_byte;
			run_last_q <= last;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (out_load) begin
			priority if (cmd.emit_run) begin
				for (int j = 0; j < NUM_LANES; j++) begin
					lane_q[j] <= (CNT_W'(j) < chunk_cnt) ? run_byte_q : '0;
				end
				cnt_q        <= chunk_cnt;
				item_last_q  <= stat.run_final;
				stream_end_q <= stat.run_final && run_last_q;
			end else if (cmd.emit_lit) begin
				lane_q[0] <= data_byte;
				for (int j = 1; j < NUM_LANES; j++) begin
					lane_q[j] <= '0;
				end
				cnt_q        <= CNT_W'(1);
				item_last_q  <= 1'b1;
				stream_end_q <= last;
			end else begin
				for (int j = 0; j < NUM_LANES; j++) begin
					lane_q[j] <= '0;
				end
				cnt_q        <= '0;
				item_last_q  <= 1'b1;
				stream_end_q <= 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign lane0       = lane_q[0];
	assign lane1       = lane_q[1];
	assign lane2       = lane_q[2];
	assign lane3       = lane_q[3];
	assign valid_count = cnt_q;
	assign item_last   = item_last_q;
	assign stream_end  = stream_end_q;

endmodule

FILE: hdl/packbits_rle_decoder_unit.sv
// Packbits run-length decoder: one compressed byte per input transaction,
// up to four decoded bytes per output transaction. Depends on pbrle_pkg,
// pbrle_ctrl and pbrle_dp.
//
// A header byte (read as signed) of zero or below starts a run of 1-h copies
// of the next byte; 1..127 starts a literal of h+1 bytes. Headers produce no
// output, except a header flagged last, which is dropped and gives one empty
// transaction (valid_count 0, item_last and stream_end set). Each literal byte
// gives one single-lane output. A run data byte is captured, then the run
// expands at four copies per cycle through the output register whenever that
// register is free, holding input off until the last chunk is loaded; the
// expansion counter in the datapath counts copies left. Output backpressure
// stalls input only while the output register is full and not taken.
module packbits_rle_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pbrle_pkg::BYTE_W-1:0]      data_byte,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pbrle_pkg::BYTE_W-1:0]      lane0,
	output logic [pbrle_pkg::BYTE_W-1:0]      lane1,
	output logic [pbrle_pkg::BYTE_W-1:0]      lane2,
	output logic [pbrle_pkg::BYTE_W-1:0]      lane3,
	output logic [pbrle_pkg::CNT_W-1:0]       valid_count,
	output logic                              item_last,
	output logic                              stream_end
);
	import pbrle_pkg::*;

	pbrle_cmd_t  cmd;
	pbrle_stat_t stat;

	// controller
	pbrle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	pbrle_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.last        (last),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.lane0       (lane0),
		.lane1       (lane1),
		.lane2       (lane2),
		.lane3       (lane3),
		.valid_count (valid_count),
		.item_last   (item_last),
		.stream_end  (stream_end)
	);

endmodule
